// File: design/lobm_pkg.sv
// Package for the limit order book matcher: request and result codes, slot and result record types.
// No dependencies.
`default_nettype none
package lobm_pkg;
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_MATCH  = 2'd2;

  localparam logic [2:0] CODE_ADDED     = 3'd0;
  localparam logic [2:0] CODE_CANCELLED = 3'd1;
  localparam logic [2:0] CODE_NOT_FOUND = 3'd2;
  localparam logic [2:0] CODE_DUP_ID    = 3'd3;
  localparam logic [2:0] CODE_FULL      = 3'd4;
  localparam logic [2:0] CODE_TRADE     = 3'd5;
  localparam logic [2:0] CODE_NO_MATCH  = 3'd6;

  localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] key;
    logic        side;
    logic        resting;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [31:0] filled;
    logic [47:0] otime;
    logic [31:0] arrival;
  } slot_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [31:0] ref_id;
    logic [31:0] sell_id;
    logic [31:0] tid;
    logic [31:0] tprice;
    logic [31:0] tqty;
    logic [47:0] ttime;
    logic [31:0] bid;
    logic [31:0] ask;
    logic [47:0] vol;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

// File: design/lobm_slot_mem.sv
// Slot table memory for the order book matcher: one write port, one registered read port.
// Depends on lobm_pkg.
`default_nettype none
module lobm_slot_mem
  import lobm_pkg::*;
#(
  parameter int Depth = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire slot_t         wdata,
  input  wire logic [AW-1:0] raddr,
  output slot_t              rdata
);
  slot_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/limit_order_book_matcher.sv
// Top level of the limit order book matcher: sequencer over the slot table.
// Depends on lobm_pkg and lobm_slot_mem.
//
// The book lives in a synchronous slot memory read one slot per cycle, with a valid
// flag per slot in flip-flops. Every request first scans all BOOK_SLOTS slots to find
// the id, the lowest free slot and the best bid and ask. Duplicate, full, not-found,
// no-match and unused requests answer after that scan alone. A successful add writes
// one slot, a successful cancel clears its valid flag, and either then rescans for the
// reported best prices. Each trade of a match reads both slots, writes both back and
// rescans; each trade result leaves as the next trade starts. The single read port
// paces the trades. One request is handled at a time, and a result still held on the
// output stalls the next trade.
`default_nettype none
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int BOOK_SLOTS       = 256,
  parameter int TRADES_PER_MATCH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_order_id,
  input  wire logic        in_side,
  input  wire logic        in_is_limit,
  input  wire logic [31:0] in_price,
  input  wire logic [31:0] in_quantity,
  input  wire logic [31:0] in_prior_fill,
  input  wire logic [47:0] in_request_time,
  input  wire logic [6:0]  in_max_trades,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_code,
  output logic [31:0]      out_ref_order_id,
  output logic [31:0]      out_seller_id,
  output logic [31:0]      out_trade_num,
  output logic [31:0]      out_trade_price,
  output logic [31:0]      out_trade_quantity,
  output logic [47:0]      out_trade_time,
  output logic [31:0]      out_bid_px,
  output logic [31:0]      out_ask_px,
  output logic [47:0]      out_volume,
  output logic             out_last
);
  localparam int AW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
  localparam int CW = AW + 1;
  localparam logic [6:0] TLIM = 7'(TRADES_PER_MATCH);
  localparam logic [CW-1:0] NSLOT = CW'(BOOK_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_RDB, S_RDB2, S_RDA, S_RDA2, S_TRADE, S_EMIT
  } state_t;

  state_t state_r;
  logic [BOOK_SLOTS-1:0] valid_r;

  logic [1:0]  func_r;
  logic [31:0] id_r;
  logic        side_r, lim_r;
  logic [31:0] price_r, qty_r, fill_r;
  logic [47:0] time_r;
  logic [6:0]  limit_r, ntr_r;

  logic [31:0] arrival_r, tcnt_r;
  logic [47:0] vol_r;

  logic [CW-1:0] rcnt_r;
  logic [AW-1:0] raddr_prev_r;
  logic          rvld_r;
  logic          found_r, free_ok_r, b_ok_r, a_ok_r;
  logic [AW-1:0] found_idx_r, free_idx_r, b_idx_r, a_idx_r;
  logic [31:0]   b_px_r, a_px_r, b_arr_r, a_arr_r;
  slot_t         bs_r, as_r;

  logic          out_valid_r;
  logic          pend_r;
  result_t       res_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  slot_t         wdata, rdata;

  lobm_slot_mem #(.Depth(BOOK_SLOTS), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_code = res_r.code;
  assign out_ref_order_id = res_r.ref_id;
  assign out_seller_id = res_r.sell_id;
  assign out_trade_num = res_r.tid;
  assign out_trade_price = res_r.tprice;
  assign out_trade_quantity = res_r.tqty;
  assign out_trade_time = res_r.ttime;
  assign out_bid_px = res_r.bid;
  assign out_ask_px = res_r.ask;
  assign out_volume = res_r.vol;
  assign out_last = res_r.last;

  // trade arithmetic
  logic [31:0] rem_b, rem_a, tq, tp, fb_n, fa_n;
  logic [48:0] vsum;
  always_comb begin
    rem_b = (bs_r.filled >= bs_r.quantity) ? 32'd0 : bs_r.quantity - bs_r.filled;
    rem_a = (as_r.filled >= as_r.quantity) ? 32'd0 : as_r.quantity - as_r.filled;
    tq = (rem_b < rem_a) ? rem_b : rem_a;
    tp = (bs_r.otime < as_r.otime) ? bs_r.price : as_r.price;
    fb_n = bs_r.filled + tq;
    fa_n = as_r.filled + tq;
    vsum = {1'b0, vol_r} + {17'd0, tq};
  end

  logic crossing;
  assign crossing = b_ok_r && a_ok_r && (b_px_r >= a_px_r) && (ntr_r < limit_r);

  // a pending result leaves after its rescan; others leave from S_EMIT
  logic emit_go;
  assign emit_go = (state_r == S_DECIDE && pend_r && (!out_valid_r || out_ready)) ||
                   (state_r == S_EMIT && !pend_r);

  always_comb begin
    raddr = rcnt_r[AW-1:0];
    if (state_r == S_RDB) raddr = b_idx_r;
    if (state_r == S_RDA) raddr = a_idx_r;
    we = 1'b0;
    waddr = free_idx_r;
    wdata = '{key: id_r, side: side_r, resting: lim_r, price: price_r, quantity: qty_r,
              filled: fill_r, otime: time_r, arrival: arrival_r};
    if (state_r == S_DECIDE && !pend_r && func_r == FUNC_ADD && !found_r && free_ok_r)
      we = 1'b1;
    if (state_r == S_TRADE) begin
      we = 1'b1;
      waddr = b_idx_r;
      wdata = bs_r;
      wdata.filled = fb_n;
    end
    if (state_r == S_EMIT && pend_r && res_r.code == CODE_TRADE) begin
      we = 1'b1;
      waddr = a_idx_r;
      wdata = as_r;
    end
  end

  function automatic result_t mk(input logic [2:0] c, input logic [31:0] r);
    result_t x;
    x = '0;
    x.code = c;
    x.ref_id = r;
    return x;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      out_valid_r <= 1'b0;
      pend_r <= 1'b0;
      arrival_r <= '0;
      tcnt_r <= 32'd1;
      vol_r <= '0;
      rvld_r <= 1'b0;
    end else begin
      out_valid_r <= emit_go || (out_valid_r && !out_ready);
      rvld_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            func_r <= in_func;  id_r <= in_order_id;  side_r <= in_side;
            lim_r <= in_is_limit;  price_r <= in_price;  qty_r <= in_quantity;
            fill_r <= in_prior_fill;  time_r <= in_request_time;
            limit_r <= (in_max_trades > TLIM) ? TLIM : in_max_trades;
            ntr_r <= '0;
            rcnt_r <= '0;
            found_r <= 1'b0; free_ok_r <= 1'b0; b_ok_r <= 1'b0; a_ok_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rcnt_r < NSLOT) begin
            rcnt_r <= rcnt_r + 1'b1;
            raddr_prev_r <= rcnt_r[AW-1:0];
            rvld_r <= 1'b1;
          end else if (!rvld_r) begin
            state_r <= S_DECIDE;
          end
          if (rvld_r) begin
            if (valid_r[raddr_prev_r]) begin
              if (rdata.key == id_r && !found_r) begin
                found_r <= 1'b1;
                found_idx_r <= raddr_prev_r;
              end
              if (rdata.resting && !rdata.side &&
                  (!b_ok_r || rdata.price > b_px_r ||
                   (rdata.price == b_px_r && rdata.arrival < b_arr_r))) begin
                b_ok_r <= 1'b1; b_idx_r <= raddr_prev_r;
                b_px_r <= rdata.price; b_arr_r <= rdata.arrival;
              end
              if (rdata.resting && rdata.side &&
                  (!a_ok_r || rdata.price < a_px_r ||
                   (rdata.price == a_px_r && rdata.arrival < a_arr_r))) begin
                a_ok_r <= 1'b1; a_idx_r <= raddr_prev_r;
                a_px_r <= rdata.price; a_arr_r <= rdata.arrival;
              end
            end else if (!free_ok_r) begin
              free_ok_r <= 1'b1;
              free_idx_r <= raddr_prev_r;
            end
          end
        end
        S_DECIDE: begin
          if (!out_valid_r || out_ready) begin
            if (pend_r) begin
              res_r.bid <= b_ok_r ? b_px_r : 32'd0;
              res_r.ask <= a_ok_r ? a_px_r : 32'd0;
              res_r.vol <= vol_r;
              res_r.last <= !(func_r == FUNC_MATCH && crossing);
              pend_r <= 1'b0;
              state_r <= (func_r == FUNC_MATCH && crossing) ? S_RDB : S_IDLE;
            end else begin
              case (func_r)
                FUNC_ADD: begin
                  if (found_r) res_r <= mk(CODE_DUP_ID, id_r);
                  else if (!free_ok_r) res_r <= mk(CODE_FULL, id_r);
                  else begin
                    res_r <= mk(CODE_ADDED, id_r);
                    valid_r[free_idx_r] <= 1'b1;
                    arrival_r <= arrival_r + 32'd1;
                    pend_r <= 1'b1;
                  end
                  state_r <= S_EMIT;
                end
                FUNC_CANCEL: begin
                  if (found_r) begin
                    res_r <= mk(CODE_CANCELLED, id_r);
                    valid_r[found_idx_r] <= 1'b0;
                    pend_r <= 1'b1;
                  end else res_r <= mk(CODE_NOT_FOUND, id_r);
                  state_r <= S_EMIT;
                end
                FUNC_MATCH: begin
                  if (crossing) state_r <= S_RDB;
                  else begin
                    res_r <= mk(CODE_NO_MATCH, 32'd0);
                    state_r <= S_EMIT;
                  end
                end
                default: begin
                  res_r <= mk(CODE_NO_MATCH, 32'd0);
                  state_r <= S_EMIT;
                end
              endcase
            end
          end
        end
        S_RDB: state_r <= S_RDB2;
        S_RDB2: begin
          bs_r <= rdata;
          state_r <= S_RDA;
        end
        S_RDA: state_r <= S_RDA2;
        S_RDA2: begin
          as_r <= rdata;
          state_r <= S_TRADE;
        end
        S_TRADE: begin
          // ask fill is kept in as_r and written back in S_EMIT
          if (!out_valid_r || out_ready) begin
            if (fb_n >= bs_r.quantity) valid_r[b_idx_r] <= 1'b0;
            if (fa_n >= as_r.quantity) valid_r[a_idx_r] <= 1'b0;
            as_r.filled <= fa_n;
            tcnt_r <= tcnt_r + 32'd1;
            vol_r <= vsum[48] ? VOL_MAX : vsum[47:0];
            res_r.code <= CODE_TRADE;
            res_r.ref_id <= bs_r.key;
            res_r.sell_id <= as_r.key;
            res_r.tid <= tcnt_r;
            res_r.tprice <= tp;
            res_r.tqty <= tq;
            res_r.ttime <= time_r;
            res_r.last <= 1'b0;
            ntr_r <= ntr_r + 7'd1;
            pend_r <= 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // rescan for best prices after a change to the book
          if (pend_r) begin
            rcnt_r <= '0;
            found_r <= 1'b0; free_ok_r <= 1'b0; b_ok_r <= 1'b0; a_ok_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            res_r.bid <= b_ok_r ? b_px_r : 32'd0;
            res_r.ask <= a_ok_r ? a_px_r : 32'd0;
            res_r.vol <= vol_r;
            res_r.last <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("accept while busy");
  a_trade_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TRADE |-> ntr_r < limit_r)
    else $error("trade limit exceeded");
`endif
endmodule
`default_nettype wire
